[hw/rtl/quat_relative_orientation_macros.svh]
// ----------------------------------------------------------------------------
// quat_relative_orientation assertion macros
// shared concurrent assertion shorthands, clocked on clk, quiet in reset
// ----------------------------------------------------------------------------
`ifndef QUAT_RELATIVE_ORIENTATION_MACROS_SVH
`define QUAT_RELATIVE_ORIENTATION_MACROS_SVH

// same-cycle implication
`define QRO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define QRO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/qro_pkg.sv]
// ----------------------------------------------------------------------------
// qro_pkg
// shared types, codes and term tables of the relative orientation block
// ----------------------------------------------------------------------------
package qro_pkg;

  localparam int WORD_BITS_DEF = 16;
  localparam int CFG_IDX_BITS  = 2;

  // quaternion part positions
  localparam logic [1:0] QI_X = 2'd0;
  localparam logic [1:0] QI_Y = 2'd1;
  localparam logic [1:0] QI_Z = 2'd2;
  localparam logic [1:0] QI_W = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_OFFSET_X = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_OFFSET_Y = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_OFFSET_Z = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_OFFSET_W = 2'd3;

  // product codes, in the order they are run
  localparam logic [1:0] PROD_HEAD = 2'd0;  // head_ref * head
  localparam logic [1:0] PROD_BACK = 2'd1;  // back_ref * back, stored conjugated
  localparam logic [1:0] PROD_REL  = 2'd2;  // conj(back') * head'
  localparam logic [1:0] PROD_OUT  = 2'd3;  // offset * rel

  typedef struct packed {
    logic       issue;
    logic [1:0] prod;
    logic [1:0] part;
    logic [1:0] term;
    logic       load;
    logic       capture;
    logic       publish;
  } cmd_t;

  typedef struct packed {
    logic [1:0] a_idx;
    logic [1:0] b_idx;
    logic       neg;
  } term_sel_t;

  // hamilton product terms: the left operand walks w, x, y, z for every part
  localparam logic [1:0] A_SEL [4] = '{QI_W, QI_X, QI_Y, QI_Z};

  localparam logic [1:0] B_SEL [4][4] = '{
    '{QI_X, QI_W, QI_Z, QI_Y},
    '{QI_Y, QI_Z, QI_W, QI_X},
    '{QI_Z, QI_Y, QI_X, QI_W},
    '{QI_W, QI_X, QI_Y, QI_Z}
  };

  localparam logic NEG_SEL [4][4] = '{
    '{1'b0, 1'b0, 1'b0, 1'b1},
    '{1'b0, 1'b1, 1'b0, 1'b0},
    '{1'b0, 1'b0, 1'b1, 1'b0},
    '{1'b0, 1'b1, 1'b1, 1'b1}
  };

  function automatic term_sel_t term_sel(input logic [1:0] part, input logic [1:0] term);
    term_sel_t s;
    s.a_idx = A_SEL[term];
    s.b_idx = B_SEL[part][term];
    s.neg   = NEG_SEL[part][term];
    return s;
  endfunction

endpackage

[hw/rtl/qro_in_if.sv]
// ----------------------------------------------------------------------------
// qro_in_if
// input channel: function code plus back and head quaternions
// ----------------------------------------------------------------------------
interface qro_in_if #(
  parameter int WORD_BITS = qro_pkg::WORD_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic signed [WORD_BITS-1:0] back_x;
  logic signed [WORD_BITS-1:0] back_y;
  logic signed [WORD_BITS-1:0] back_z;
  logic signed [WORD_BITS-1:0] back_w;
  logic signed [WORD_BITS-1:0] head_x;
  logic signed [WORD_BITS-1:0] head_y;
  logic signed [WORD_BITS-1:0] head_z;
  logic signed [WORD_BITS-1:0] head_w;

  modport source (
    output valid, func, back_x, back_y, back_z, back_w, head_x, head_y, head_z, head_w,
    input  ready
  );
  modport sink (
    input  valid, func, back_x, back_y, back_z, back_w, head_x, head_y, head_z, head_w,
    output ready
  );
endinterface

[hw/rtl/qro_out_if.sv]
// ----------------------------------------------------------------------------
// qro_out_if
// result channel: relative head orientation quaternion
// ----------------------------------------------------------------------------
interface qro_out_if #(
  parameter int WORD_BITS = qro_pkg::WORD_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] out_x;
  logic signed [WORD_BITS-1:0] out_y;
  logic signed [WORD_BITS-1:0] out_z;
  logic signed [WORD_BITS-1:0] out_w;

  modport source (output valid, out_x, out_y, out_z, out_w, input ready);
  modport sink (input valid, out_x, out_y, out_z, out_w, output ready);
endinterface

[hw/rtl/qro_ctrl.sv]
// ----------------------------------------------------------------------------
// qro_ctrl
// sequencer: walks 4 products x 4 parts x 4 terms through the datapath
// ----------------------------------------------------------------------------
`include "quat_relative_orientation_macros.svh"

module qro_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_func,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output qro_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_DRAIN,
    S_PUBLISH
  } state_t;

  state_t     state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;  // {prod, part, term}
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd_o         = '0;
    cmd_o.prod    = cnt_r[5:4];
    cmd_o.part    = cnt_r[3:2];
    cmd_o.term    = cnt_r[1:0];
    case (state_r)
      S_IDLE: begin
        cmd_o.load    = in_valid;
        cmd_o.capture = in_valid && in_func;
        if (in_valid && !in_func) begin
          state_nxt = S_ISSUE;
          cnt_nxt   = '0;
        end
      end
      S_ISSUE: begin
        cmd_o.issue = 1'b1;
        cnt_nxt     = cnt_r + 6'd1;
        // a drain state after each product so the last part is written back
        if (cnt_r[3:0] == 4'hF) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (cnt_r == '0) begin
          state_nxt = S_PUBLISH;
        end else begin
          state_nxt = S_ISSUE;
        end
      end
      S_PUBLISH: begin
        if (!out_valid_r || out_ready) begin
          cmd_o.publish = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `QRO_ASSERT_NOW(a_ready_quiet, in_ready, !cmd_o.issue && !cmd_o.publish, "issue while idle")
  `QRO_ASSERT_NOW(a_publish_free, cmd_o.publish, !out_valid_r || out_ready, "result overwritten")
  `QRO_ASSERT_NEXT(a_publish_shows, cmd_o.publish, out_valid_r, "published word not shown")
  `QRO_ASSERT_NEXT(a_update_starts, in_valid && in_ready && !in_func, cmd_o.issue && cnt_r == '0, "update did not start")
  `QRO_ASSERT_NOW(a_drain_aligned, state_r == S_DRAIN, cnt_r[3:0] == 4'h0, "drain off product boundary")

endmodule

[hw/rtl/qro_datapath.sv]
// ----------------------------------------------------------------------------
// qro_datapath
// quaternion registers, one shared multiplier, accumulate, shift and saturate
// ----------------------------------------------------------------------------
module qro_datapath #(
  parameter int WORD_BITS = qro_pkg::WORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  qro_pkg::cmd_t                         cmd,
  input  logic                                  cfg_we,
  input  logic        [qro_pkg::CFG_IDX_BITS-1:0] cfg_idx,
  input  logic signed [WORD_BITS-1:0]           cfg_wdata,
  input  logic signed [WORD_BITS-1:0]           back_i [4],
  input  logic signed [WORD_BITS-1:0]           head_i [4],
  output logic signed [WORD_BITS-1:0]           res_o  [4]
);

  localparam int W    = WORD_BITS;
  localparam int PW   = 2 * W;
  localparam int AW   = PW + 2;
  localparam int FRAC = W - 2;

  localparam logic signed [W-1:0]  WMAX   = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  WMIN   = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0]  ONE    = {2'b01, {FRAC{1'b0}}};
  localparam logic signed [AW-1:0] SAT_HI = {{(AW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [AW-1:0] SAT_LO = {{(AW-W+1){1'b1}}, {(W-1){1'b0}}};

  function automatic logic signed [W-1:0] neg_sat(input logic signed [W-1:0] v);
    return (v == WMIN) ? WMAX : -v;
  endfunction

  logic signed [W-1:0] head_r [4];
  logic signed [W-1:0] back_r [4];
  logic signed [W-1:0] href_r [4];
  logic signed [W-1:0] bref_r [4];
  logic signed [W-1:0] off_r  [4];
  logic signed [W-1:0] hp_r   [4];  // head', later reused for the final product
  logic signed [W-1:0] bc_r   [4];  // conj(back')
  logic signed [W-1:0] rel_r  [4];
  logic signed [W-1:0] res_r  [4];

  // operand select and multiply
  qro_pkg::term_sel_t  sel;
  logic signed [W-1:0] a_op;
  logic signed [W-1:0] b_op;
  logic signed [PW-1:0] mul;

  assign sel = qro_pkg::term_sel(cmd.part, cmd.term);

  always_comb begin
    case (cmd.prod)
      qro_pkg::PROD_HEAD: begin
        a_op = href_r[sel.a_idx];
        b_op = head_r[sel.b_idx];
      end
      qro_pkg::PROD_BACK: begin
        a_op = bref_r[sel.a_idx];
        b_op = back_r[sel.b_idx];
      end
      qro_pkg::PROD_REL: begin
        a_op = bc_r[sel.a_idx];
        b_op = hp_r[sel.b_idx];
      end
      default: begin
        a_op = off_r[sel.a_idx];
        b_op = rel_r[sel.b_idx];
      end
    endcase
  end

  assign mul = a_op * b_op;

  // product stage
  logic signed [PW-1:0] mul_r;
  logic                 p_vld_r;
  logic                 p_neg_r;
  logic                 p_first_r;
  logic                 p_last_r;
  logic [1:0]           p_prod_r;
  logic [1:0]           p_part_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    mul_r     <= mul;
    p_neg_r   <= sel.neg;
    p_first_r <= (cmd.term == 2'd0);
    p_last_r  <= (cmd.term == 2'd3);
    p_prod_r  <= cmd.prod;
    p_part_r  <= cmd.part;
  end

  // accumulate stage, floor shift and saturate on the fourth term
  logic signed [AW-1:0] acc_r;
  logic signed [AW-1:0] term_ext;
  logic signed [AW-1:0] addend;
  logic signed [AW-1:0] sum;
  logic signed [AW-1:0] sh;
  logic signed [W-1:0]  word;

  always_comb begin
    term_ext = AW'(mul_r);
    addend   = p_neg_r ? -term_ext : term_ext;
    sum      = (p_first_r ? '0 : acc_r) + addend;
    sh       = sum >>> FRAC;
    if (sh > SAT_HI) begin
      word = WMAX;
    end else if (sh < SAT_LO) begin
      word = WMIN;
    end else begin
      word = sh[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (p_vld_r) begin
      acc_r <= sum;
    end
    if (p_vld_r && p_last_r) begin
      case (p_prod_r)
        qro_pkg::PROD_HEAD: hp_r[p_part_r] <= word;
        qro_pkg::PROD_BACK: begin
          bc_r[p_part_r] <= (p_part_r == qro_pkg::QI_W) ? word : neg_sat(word);
        end
        qro_pkg::PROD_REL:  rel_r[p_part_r] <= word;
        default:            hp_r[p_part_r] <= word;
      endcase
    end
  end

  // input words and result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < 4; i++) begin
        head_r[i] <= head_i[i];
        back_r[i] <= back_i[i];
      end
    end
    if (cmd.publish) begin
      for (int i = 0; i < 4; i++) begin
        res_r[i] <= hp_r[i];
      end
    end
  end

  assign res_o = res_r;

  // references: conjugates of the captured quaternions
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        href_r[i] <= '0;
        bref_r[i] <= '0;
      end
      href_r[3] <= ONE;
      bref_r[3] <= ONE;
    end else if (cmd.capture) begin
      for (int i = 0; i < 3; i++) begin
        href_r[i] <= neg_sat(head_i[i]);
        bref_r[i] <= neg_sat(back_i[i]);
      end
      href_r[3] <= head_i[3];
      bref_r[3] <= back_i[3];
    end
  end

  // offset quaternion
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r[0] <= '0;
      off_r[1] <= '0;
      off_r[2] <= '0;
      off_r[3] <= ONE;
    end else if (cfg_we) begin
      case (cfg_idx)
        qro_pkg::CFG_OFFSET_X: off_r[0] <= cfg_wdata;
        qro_pkg::CFG_OFFSET_Y: off_r[1] <= cfg_wdata;
        qro_pkg::CFG_OFFSET_Z: off_r[2] <= cfg_wdata;
        qro_pkg::CFG_OFFSET_W: off_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

[hw/rtl/quat_relative_orientation.sv]
// update word: the input stays busy from accept until the result is published
// the single shared multiplier runs 64 products, 16 per quaternion product,
// with a drain state after each product; a capture word gives no result
// the result register holds while the next word is accepted and computed
// reset (synchronous, rst_n low): references and offset return to identity
// ----------------------------------------------------------------------------
// quat_relative_orientation
// head orientation relative to back, from tracker quaternions in Q2.14
// ----------------------------------------------------------------------------
module quat_relative_orientation #(
  parameter int WORD_BITS = qro_pkg::WORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  qro_in_if.sink                                in_ch,
  qro_out_if.source                             out_ch,
  input  logic                                  cfg_we,
  input  logic        [qro_pkg::CFG_IDX_BITS-1:0] cfg_idx,
  input  logic signed [WORD_BITS-1:0]           cfg_wdata
);

  qro_pkg::cmd_t               cmd;
  logic signed [WORD_BITS-1:0] back_w [4];
  logic signed [WORD_BITS-1:0] head_w [4];
  logic signed [WORD_BITS-1:0] res_w  [4];

  assign back_w[0] = in_ch.back_x;
  assign back_w[1] = in_ch.back_y;
  assign back_w[2] = in_ch.back_z;
  assign back_w[3] = in_ch.back_w;
  assign head_w[0] = in_ch.head_x;
  assign head_w[1] = in_ch.head_y;
  assign head_w[2] = in_ch.head_z;
  assign head_w[3] = in_ch.head_w;

  qro_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_func   (in_ch.func),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd_o     (cmd)
  );

  qro_datapath #(
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .back_i    (back_w),
    .head_i    (head_w),
    .res_o     (res_w)
  );

  assign out_ch.out_x = res_w[0];
  assign out_ch.out_y = res_w[1];
  assign out_ch.out_z = res_w[2];
  assign out_ch.out_w = res_w[3];

endmodule

[tb/quat_relative_orientation_tb.sv]
// ----------------------------------------------------------------------------
// quat_relative_orientation_tb
// drives back and head quaternion words into the block with random idle
// gaps, recomputes the relative orientation in its own Q2.14 arithmetic and
// compares each result word with the oldest expected quaternion
// ----------------------------------------------------------------------------
module quat_relative_orientation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     WB            = qro_pkg::WORD_BITS_DEF;
  localparam int     FRAC          = WB - 2;
  localparam longint PART_MAX      = (longint'(1) <<< (WB - 1)) - 1;
  localparam longint PART_MIN      = -PART_MAX - 1;
  localparam longint ONE           = longint'(1) <<< FRAC;
  localparam bit     FUNC_UPDATE   = 1'b0;
  localparam bit     FUNC_CAPTURE  = 1'b1;
  localparam int     NPHASE        = 8;
  localparam int     PHASE_WORDS   = 160;
  localparam int     SETTLE_CYCLES = 100;
  localparam int     CYCLE_LIMIT   = 1000000;

  typedef logic signed [WB-1:0] part_t;
  typedef struct packed {
    part_t x;
    part_t y;
    part_t z;
    part_t w;
  } quat_t;

  // what the driver knows about a word before it is accepted
  typedef struct packed {
    bit    typed;
    quat_t want;
  } tag_t;

  typedef struct packed {
    bit    func;
    quat_t back;
    quat_t head;
    bit    typed;
    quat_t want;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic                             cfg_we;
  logic [qro_pkg::CFG_IDX_BITS-1:0] cfg_idx;
  logic signed [WB-1:0]             cfg_wdata;

  qro_in_if  #(.WORD_BITS(WB)) in_ch ();
  qro_out_if #(.WORD_BITS(WB)) out_ch ();

  quat_relative_orientation #(.WORD_BITS(WB)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  // predictor state
  quat_t back_ref;
  quat_t head_ref;
  quat_t offset_q;

  quat_t    rel_expect_q[$];
  tag_t     word_tag_q[$];
  dir_row_t dir_rows[$];
  quat_t    phase_offsets[NPHASE];

  int     mismatches = 0;
  int     cycles = 0;
  int     src_burst;
  int     snk_burst = 0;
  int     hold_left = 0;
  int     taken = 0;
  quat_t  got_q;
  quat_t  want_q;
  quat_t  in_back;
  quat_t  in_head;
  tag_t   in_tag;

  // ---------------------------------------------------------------- predictor

  function automatic quat_t mkq(input longint x, input longint y, input longint z,
                                input longint w);
    quat_t r;
    r.x = x[WB-1:0];
    r.y = y[WB-1:0];
    r.z = z[WB-1:0];
    r.w = w[WB-1:0];
    return r;
  endfunction

  function automatic part_t clamp_part(input longint v);
    longint c;
    c = (v > PART_MAX) ? PART_MAX : (v < PART_MIN) ? PART_MIN : v;
    return c[WB-1:0];
  endfunction

  // exact sum, floor shift, saturate
  function automatic part_t fold_terms(input longint t0, input longint t1,
                                       input longint t2, input longint t3);
    longint s;
    s = t0 + t1 + t2 + t3;
    return clamp_part(s >>> FRAC);
  endfunction

  function automatic quat_t hamilton(input quat_t a, input quat_t b);
    longint ax, ay, az, aw, bx, by, bz, bw;
    quat_t  r;
    ax = a.x; ay = a.y; az = a.z; aw = a.w;
    bx = b.x; by = b.y; bz = b.z; bw = b.w;
    r.x = fold_terms(aw * bx, ax * bw, ay * bz, -(az * by));
    r.y = fold_terms(aw * by, -(ax * bz), ay * bw, az * bx);
    r.z = fold_terms(aw * bz, ax * by, -(ay * bx), az * bw);
    r.w = fold_terms(aw * bw, -(ax * bx), -(ay * by), -(az * bz));
    return r;
  endfunction

  // negating the most negative part saturates
  function automatic quat_t conjugate(input quat_t a);
    longint ax, ay, az;
    quat_t  r;
    ax = a.x; ay = a.y; az = a.z;
    r.x = clamp_part(-ax);
    r.y = clamp_part(-ay);
    r.z = clamp_part(-az);
    r.w = a.w;
    return r;
  endfunction

  function automatic quat_t relative_orientation(input quat_t back, input quat_t head);
    quat_t head_p;
    quat_t back_p;
    head_p = hamilton(head_ref, head);
    back_p = hamilton(back_ref, back);
    return hamilton(offset_q, hamilton(conjugate(back_p), head_p));
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic dir_row_t mkrow(input bit func, input quat_t back, input quat_t head,
                                     input bit typed, input quat_t want);
    dir_row_t r;
    r.func  = func;
    r.back  = back;
    r.head  = head;
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  function automatic part_t rand_part();
    longint v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: v = PART_MIN;
          1: v = PART_MAX;
          2: v = 0;
          3: v = ONE;
          default: v = -ONE;
        endcase
      end
      1, 2, 3, 4, 5: v = longint'($urandom_range(0, 2 * ONE)) - ONE;  // near unit
      default: v = $urandom();
    endcase
    return v[WB-1:0];
  endfunction

  function automatic quat_t rand_quat();
    return mkq(rand_part(), rand_part(), rand_part(), rand_part());
  endfunction

  // zero-gap bursts now and then, else a random gap
  task automatic draw_gap(inout int burst, output int gap);
    if (burst > 0) begin
      burst--;
      gap = 0;
    end else if ($urandom_range(0, 15) == 0) begin
      burst = $urandom_range(20, 60);
      gap = 0;
    end else begin
      gap = $urandom_range(0, 19);
    end
  endtask

  task automatic send_word(input bit func, input quat_t back, input quat_t head,
                           input bit typed, input quat_t want);
    int   gap;
    tag_t t;
    t.typed = typed;
    t.want  = want;
    word_tag_q.push_back(t);
    draw_gap(src_burst, gap);
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid  <= 1'b1;
    in_ch.func   <= func;
    in_ch.back_x <= back.x;
    in_ch.back_y <= back.y;
    in_ch.back_z <= back.z;
    in_ch.back_w <= back.w;
    in_ch.head_x <= head.x;
    in_ch.head_y <= head.y;
    in_ch.head_z <= head.z;
    in_ch.head_w <= head.w;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // capture words give no result, so wait out the compute time as well
  task automatic drain_and_settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (rel_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_offsets(input quat_t o);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= qro_pkg::CFG_OFFSET_X;
    cfg_wdata <= o.x;
    @(negedge clk);
    cfg_idx   <= qro_pkg::CFG_OFFSET_Y;
    cfg_wdata <= o.y;
    @(negedge clk);
    cfg_idx   <= qro_pkg::CFG_OFFSET_Z;
    cfg_wdata <= o.z;
    @(negedge clk);
    cfg_idx   <= qro_pkg::CFG_OFFSET_W;
    cfg_wdata <= o.w;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic check_part(input string name, input part_t want, input part_t got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------- clock and limit

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- monitors

  always @(posedge clk) begin
    if (!rst_n) begin
      back_ref = mkq(0, 0, 0, ONE);
      head_ref = mkq(0, 0, 0, ONE);
      offset_q = mkq(0, 0, 0, ONE);
    end
    if (rst_n && cfg_we) begin
      case (cfg_idx)
        qro_pkg::CFG_OFFSET_X: offset_q.x = cfg_wdata;
        qro_pkg::CFG_OFFSET_Y: offset_q.y = cfg_wdata;
        qro_pkg::CFG_OFFSET_Z: offset_q.z = cfg_wdata;
        qro_pkg::CFG_OFFSET_W: offset_q.w = cfg_wdata;
        default: ;
      endcase
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      in_tag  = word_tag_q.pop_front();
      in_back = mkq(in_ch.back_x, in_ch.back_y, in_ch.back_z, in_ch.back_w);
      in_head = mkq(in_ch.head_x, in_ch.head_y, in_ch.head_z, in_ch.head_w);
      if (in_ch.func == FUNC_CAPTURE) begin
        back_ref = conjugate(in_back);
        head_ref = conjugate(in_head);
      end else if (in_tag.typed) begin
        rel_expect_q.push_back(in_tag.want);
      end else begin
        rel_expect_q.push_back(relative_orientation(in_back, in_head));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_q = mkq(out_ch.out_x, out_ch.out_y, out_ch.out_z, out_ch.out_w);
      if (rel_expect_q.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h", $time, got_q);
        mismatches++;
      end else begin
        want_q = rel_expect_q.pop_front();
        check_part("out_x", want_q.x, got_q.x);
        check_part("out_y", want_q.y, got_q.y);
        check_part("out_z", want_q.z, got_q.z);
        check_part("out_w", want_q.w, got_q.w);
      end
    end
  end

  // result side, with one long hold-off so the block backs up
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        taken++;
        if (taken == 300) hold_left = 600;
        else draw_gap(snk_burst, hold_left);
      end
    end
  end

  // ---------------------------------------------------------------- main sequence

  initial begin
    quat_t ident;
    quat_t zero;
    quat_t pmax;
    quat_t nmin;
    quat_t h;

    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = qro_pkg::CFG_OFFSET_X;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.func   = FUNC_UPDATE;
    in_ch.back_x = '0;
    in_ch.back_y = '0;
    in_ch.back_z = '0;
    in_ch.back_w = '0;
    in_ch.head_x = '0;
    in_ch.head_y = '0;
    in_ch.head_z = '0;
    in_ch.head_w = '0;
    src_burst    = 0;

    ident    = mkq(0, 0, 0, ONE);
    zero     = mkq(0, 0, 0, 0);
    pmax     = mkq(PART_MAX, PART_MAX, PART_MAX, PART_MAX);
    nmin     = mkq(PART_MIN, PART_MIN, PART_MIN, PART_MIN);

    // identity references and offset pass the head through unchanged
    dir_rows.push_back(mkrow(FUNC_UPDATE, ident, ident, 1, ident));
    dir_rows.push_back(mkrow(FUNC_UPDATE, ident, pmax, 1, pmax));
    dir_rows.push_back(mkrow(FUNC_UPDATE, ident, nmin, 1, nmin));
    h = mkq(ONE, -ONE, 1, -1);
    dir_rows.push_back(mkrow(FUNC_UPDATE, ident, h, 1, h));
    dir_rows.push_back(mkrow(FUNC_UPDATE, pmax, pmax, 0, zero));
    dir_rows.push_back(mkrow(FUNC_UPDATE, nmin, nmin, 0, zero));
    dir_rows.push_back(mkrow(FUNC_UPDATE, mkq(PART_MIN, PART_MAX, PART_MIN, PART_MAX),
                             ident, 0, zero));
    dir_rows.push_back(mkrow(FUNC_UPDATE, mkq(ONE, 0, 0, 0), mkq(0, ONE, 0, 0), 0, zero));
    dir_rows.push_back(mkrow(FUNC_UPDATE, mkq(0, 0, 0, PART_MIN), mkq(0, 0, 0, PART_MIN),
                             0, zero));
    // capture of most negative parts, conjugate saturates
    dir_rows.push_back(mkrow(FUNC_CAPTURE, mkq(PART_MIN, PART_MIN, PART_MIN, PART_MAX),
                             nmin, 0, zero));
    dir_rows.push_back(mkrow(FUNC_UPDATE, ident, ident, 0, zero));
    dir_rows.push_back(mkrow(FUNC_UPDATE, mkq(1, 2, 3, 4), mkq(-5, 6, -7, 8), 0, zero));
    dir_rows.push_back(mkrow(FUNC_UPDATE, mkq(-1, -1, -1, -1), mkq(-1, -1, -1, -1), 0, zero));
    // zero references wipe everything out
    dir_rows.push_back(mkrow(FUNC_CAPTURE, zero, zero, 0, zero));
    dir_rows.push_back(mkrow(FUNC_UPDATE, pmax, nmin, 1, zero));
    dir_rows.push_back(mkrow(FUNC_UPDATE, ident, ident, 1, zero));
    // back to identity references
    dir_rows.push_back(mkrow(FUNC_CAPTURE, ident, ident, 0, zero));
    h = mkq(12345, -23456, PART_MAX, PART_MIN);
    dir_rows.push_back(mkrow(FUNC_UPDATE, ident, h, 1, h));
    dir_rows.push_back(mkrow(FUNC_CAPTURE, mkq(0, 0, 0, -ONE), mkq(ONE, 0, 0, 0), 0, zero));
    dir_rows.push_back(mkrow(FUNC_UPDATE, ident, mkq(0, 0, ONE, 0), 0, zero));
    dir_rows.push_back(mkrow(FUNC_UPDATE, pmax, nmin, 0, zero));
    dir_rows.push_back(mkrow(FUNC_CAPTURE, ident, ident, 0, zero));

    phase_offsets[0] = pmax;
    phase_offsets[1] = nmin;
    phase_offsets[2] = zero;
    for (int p = 3; p < NPHASE - 1; p++) phase_offsets[p] = rand_quat();
    phase_offsets[NPHASE-1] = ident;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_word(dir_rows[i].func, dir_rows[i].back, dir_rows[i].head,
                dir_rows[i].typed, dir_rows[i].want);

    for (int p = 0; p < NPHASE; p++) begin
      drain_and_settle();
      write_offsets(phase_offsets[p]);
      repeat (PHASE_WORDS)
        send_word(($urandom_range(0, 4) == 0) ? FUNC_CAPTURE : FUNC_UPDATE,
                  rand_quat(), rand_quat(), 0, zero);
    end

    drain_and_settle();
    if (mismatches == 0 && rel_expect_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/qro_pkg.sv
hw/rtl/qro_in_if.sv
hw/rtl/qro_out_if.sv
hw/rtl/qro_ctrl.sv
hw/rtl/qro_datapath.sv
hw/rtl/quat_relative_orientation.sv
tb/quat_relative_orientation_tb.sv
